// ===== src/tmlp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmlp_pkg
// Shared types, constants and the activation table of the two-layer
// perceptron classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tmlp_pkg;

    localparam int MAX_FEATURES     = 7;
    localparam int DEF_FEATURE_COUNT = 7;
    localparam int BYTE_W           = 8;
    localparam int FRAC_BITS        = 8;
    // 255 << 8 plus seven products of 255 * 255 stays below 2**20.
    localparam int ACC_W            = 20;
    // 255 << 8 plus two products of 243 * 255 stays below 2**18.
    localparam int OUT_ACC_W        = 18;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_IDX_W        = 2;
    localparam int OUT_REG_W        = 24;

    localparam logic [BYTE_W-1:0] SAT_LIMIT       = 8'd255;
    localparam logic [BYTE_W-1:0] CLASS_THRESHOLD = 8'd128;

    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT        = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] feature_a;
        logic [BYTE_W-1:0] feature_b;
        logic [BYTE_W-1:0] feature_c;
        logic [BYTE_W-1:0] feature_d;
        logic [BYTE_W-1:0] feature_e;
        logic [BYTE_W-1:0] feature_f;
        logic [BYTE_W-1:0] feature_g;
        logic              final_sample;
    } t_in_item;

    typedef struct packed {
        logic class_bit;
        logic final_result;
    } t_out_item;

    // What travels from cell to cell: the sample and both partial sums.
    typedef struct packed {
        t_in_item         item;
        logic [ACC_W-1:0] acc_first;
        logic [ACC_W-1:0] acc_second;
    } t_cell_data;

    localparam logic [BYTE_W-1:0] ACT_TABLE [256] = '{
        8'd12,8'd12,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd14,8'd15,8'd15,
        8'd15,8'd16,8'd16,8'd16,8'd17,8'd17,8'd18,8'd18,8'd18,8'd19,8'd19,8'd20,
        8'd20,8'd21,8'd21,8'd21,8'd22,8'd22,8'd23,8'd23,8'd24,8'd24,8'd25,8'd26,
        8'd26,8'd27,8'd27,8'd28,8'd28,8'd29,8'd30,8'd30,8'd31,8'd32,8'd32,8'd33,
        8'd34,8'd34,8'd35,8'd36,8'd36,8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,
        8'd43,8'd44,8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,8'd50,8'd51,8'd52,8'd53,
        8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd66,
        8'd67,8'd68,8'd69,8'd70,8'd72,8'd73,8'd74,8'd75,8'd76,8'd78,8'd79,8'd80,
        8'd82,8'd83,8'd84,8'd86,8'd87,8'd88,8'd90,8'd91,8'd92,8'd94,8'd95,8'd97,
        8'd98,8'd99,8'd101,8'd102,8'd104,8'd105,8'd107,8'd108,8'd110,8'd111,
        8'd113,8'd114,8'd116,8'd117,8'd119,8'd120,8'd122,8'd123,8'd125,8'd126,
        8'd128,8'd129,8'd130,8'd132,8'd133,8'd135,8'd136,8'd138,
        8'd139,8'd141,8'd142,8'd144,8'd145,8'd147,8'd148,8'd150,8'd151,8'd153,
        8'd154,8'd156,8'd157,8'd158,8'd160,8'd161,8'd163,8'd164,
        8'd165,8'd167,8'd168,8'd169,8'd171,8'd172,8'd173,8'd175,8'd176,8'd177,
        8'd179,8'd180,8'd181,8'd182,8'd183,8'd185,8'd186,8'd187,
        8'd188,8'd189,8'd191,8'd192,8'd193,8'd194,8'd195,8'd196,8'd197,8'd198,
        8'd199,8'd200,8'd201,8'd202,8'd203,8'd204,8'd205,8'd206,
        8'd207,8'd208,8'd209,8'd210,8'd211,8'd211,8'd212,8'd213,8'd214,8'd215,
        8'd216,8'd216,8'd217,8'd218,8'd219,8'd219,8'd220,8'd221,
        8'd221,8'd222,8'd223,8'd223,8'd224,8'd225,8'd225,8'd226,8'd227,8'd227,
        8'd228,8'd228,8'd229,8'd229,8'd230,8'd231,8'd231,8'd232,
        8'd232,8'd233,8'd233,8'd234,8'd234,8'd234,8'd235,8'd235,8'd236,8'd236,
        8'd237,8'd237,8'd237,8'd238,8'd238,8'd239,8'd239,8'd239,
        8'd240,8'd240,8'd240,8'd241,8'd241,8'd241,8'd242,8'd242,8'd242,8'd243,
        8'd243,8'd243
    };

    function automatic logic [BYTE_W-1:0] feature_of(t_in_item item, logic [2:0] idx);
        logic [BYTE_W-1:0] f;
        unique case (idx)
            3'd0:    f = item.feature_a;
            3'd1:    f = item.feature_b;
            3'd2:    f = item.feature_c;
            3'd3:    f = item.feature_d;
            3'd4:    f = item.feature_e;
            3'd5:    f = item.feature_f;
            3'd6:    f = item.feature_g;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/tiny_mlp_binary_classifier_core.sv =====
// ----------------------------------------------------------------------------
// tiny_mlp_binary_classifier_core
// Two-layer perceptron classifier: a chain of multiply-accumulate cells,
// one per feature, followed by the activation and output neuron stage.
// ----------------------------------------------------------------------------
// A sample passes through the register of each chain cell and then the
// activation and output registers; a stall on the result side holds it.
// Throughput: one sample per cycle unless the result side stalls; each chain
// cell and output stage takes a new request when empty or its successor moves.
// Reset: synchronous, active low; clears all valid flags and the weights.
`default_nettype none

module tiny_mlp_binary_classifier_core #(
    parameter int FEATURE_COUNT = tmlp_pkg::DEF_FEATURE_COUNT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire tmlp_pkg::t_in_item                 i_in_data,
    output logic                                    o_in_stall,
    output logic                                    o_out_valid,
    output tmlp_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_out_stall,
    input  wire logic                               i_cfg_wen,
    input  wire logic [tmlp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tmlp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import tmlp_pkg::*;

    logic [CFG_DATA_W-1:0]  r_hidden_first;
    logic [CFG_DATA_W-1:0]  r_hidden_second;
    logic [OUT_REG_W-1:0]   r_output_weights;

    logic                   w_valid [FEATURE_COUNT+1];
    t_cell_data             w_data  [FEATURE_COUNT+1];
    logic                   w_en    [FEATURE_COUNT+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidden_first   <= '0;
            r_hidden_second  <= '0;
            r_output_weights <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                REG_HIDDEN_FIRST:  r_hidden_first   <= i_cfg_wdata;
                REG_HIDDEN_SECOND: r_hidden_second  <= i_cfg_wdata;
                REG_OUTPUT:        r_output_weights <= i_cfg_wdata[OUT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // The chain starts from the biases scaled to the accumulator's fraction.
    always_comb begin
        w_valid[0]           = i_in_valid;
        w_data[0].item       = i_in_data;
        w_data[0].acc_first  = ACC_W'({r_hidden_first[7:0], 8'd0});
        w_data[0].acc_second = ACC_W'({r_hidden_second[7:0], 8'd0});
    end

    assign o_in_stall = !w_en[0];

    for (genvar k = 0; k < FEATURE_COUNT; k++) begin : g_cell
        tmlp_mac_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_valid        (w_valid[k]),
            .i_data         (w_data[k]),
            .i_weight_first (r_hidden_first[BYTE_W*(k+1) +: BYTE_W]),
            .i_weight_second(r_hidden_second[BYTE_W*(k+1) +: BYTE_W]),
            .i_next_en      (w_en[k+1]),
            .o_en           (w_en[k]),
            .o_valid        (w_valid[k+1]),
            .o_data         (w_data[k+1])
        );
    end

    tmlp_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[FEATURE_COUNT]),
        .i_data       (w_data[FEATURE_COUNT]),
        .i_out_weights(r_output_weights),
        .i_out_stall  (i_out_stall),
        .o_en         (w_en[FEATURE_COUNT]),
        .o_valid      (o_out_valid),
        .o_data       (o_out_data)
    );

endmodule

`default_nettype wire

// ===== src/tmlp_mac_cell.sv =====
// ----------------------------------------------------------------------------
// tmlp_mac_cell
// One cell of the hidden-layer chain: adds the products of its feature and
// its two weights to the two hidden partial sums and hands the request on.
// ----------------------------------------------------------------------------
`default_nettype none

module tmlp_mac_cell #(
    parameter int IDX = 0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire tmlp_pkg::t_cell_data      i_data,
    input  wire logic [7:0]                i_weight_first,
    input  wire logic [7:0]                i_weight_second,
    input  wire logic                      i_next_en,
    output logic                           o_en,
    output logic                           o_valid,
    output tmlp_pkg::t_cell_data           o_data
);
    import tmlp_pkg::*;

    logic                    r_valid;
    t_cell_data              r_data;
    t_cell_data              n_data;
    logic [BYTE_W-1:0]       w_feat;
    logic [2*BYTE_W-1:0]     w_prod_first;
    logic [2*BYTE_W-1:0]     w_prod_second;

    // The cell moves when it is empty or its neighbor takes its contents.
    assign o_en = !r_valid || i_next_en;

    always_comb begin
        w_feat        = feature_of(i_data.item, 3'(IDX));
        w_prod_first  = w_feat * i_weight_first;
        w_prod_second = w_feat * i_weight_second;
        n_data            = i_data;
        n_data.acc_first  = i_data.acc_first + ACC_W'(w_prod_first);
        n_data.acc_second = i_data.acc_second + ACC_W'(w_prod_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== src/tmlp_out_stage.sv =====
// ----------------------------------------------------------------------------
// tmlp_out_stage
// Saturates the hidden sums, maps them through the activation table and
// evaluates the linear output neuron, registering its class threshold result.
// ----------------------------------------------------------------------------
`default_nettype none

module tmlp_out_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire tmlp_pkg::t_cell_data      i_data,
    input  wire logic [23:0]               i_out_weights,
    input  wire logic                      i_out_stall,
    output logic                           o_en,
    output logic                           o_valid,
    output tmlp_pkg::t_out_item            o_data
);
    import tmlp_pkg::*;

    localparam int HI_W  = ACC_W - FRAC_BITS;
    localparam int OHI_W = OUT_ACC_W - FRAC_BITS;

    logic                    r_act_valid;
    logic [BYTE_W-1:0]       r_act_first;
    logic [BYTE_W-1:0]       r_act_second;
    logic                    r_act_final;
    logic                    r_out_valid;
    t_out_item               r_out;
    logic                    w_out_en;
    logic [HI_W-1:0]         w_hi_first;
    logic [HI_W-1:0]         w_hi_second;
    logic [BYTE_W-1:0]       w_sat_first;
    logic [BYTE_W-1:0]       w_sat_second;
    logic [2*BYTE_W-1:0]     w_prod_first;
    logic [2*BYTE_W-1:0]     w_prod_second;
    logic [OUT_ACC_W-1:0]    w_out_acc;
    logic [OHI_W-1:0]        w_out_hi;
    logic [BYTE_W-1:0]       w_out_sat;
    t_out_item               n_out;

    assign w_out_en = !r_out_valid || !i_out_stall;
    assign o_en     = !r_act_valid || w_out_en;

    always_comb begin
        w_hi_first   = i_data.acc_first[ACC_W-1:FRAC_BITS];
        w_hi_second  = i_data.acc_second[ACC_W-1:FRAC_BITS];
        w_sat_first  = (w_hi_first > HI_W'(SAT_LIMIT)) ? SAT_LIMIT : w_hi_first[BYTE_W-1:0];
        w_sat_second = (w_hi_second > HI_W'(SAT_LIMIT)) ? SAT_LIMIT : w_hi_second[BYTE_W-1:0];
    end

    always_comb begin
        w_prod_first  = r_act_first * i_out_weights[15:8];
        w_prod_second = r_act_second * i_out_weights[23:16];
        w_out_acc = OUT_ACC_W'({i_out_weights[7:0], 8'd0})
                  + OUT_ACC_W'(w_prod_first)
                  + OUT_ACC_W'(w_prod_second);
        w_out_hi  = w_out_acc[OUT_ACC_W-1:FRAC_BITS];
        w_out_sat = (w_out_hi > OHI_W'(SAT_LIMIT)) ? SAT_LIMIT : w_out_hi[BYTE_W-1:0];
        n_out.class_bit    = (w_out_sat > CLASS_THRESHOLD);
        n_out.final_result = r_act_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_en) begin
                r_act_valid <= i_valid;
            end
            if (w_out_en) begin
                r_out_valid <= r_act_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_act_first  <= ACT_TABLE[w_sat_first];
            r_act_second <= ACT_TABLE[w_sat_second];
            r_act_final  <= i_data.item.final_sample;
        end
        if (w_out_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
